// ===== rtl/ilb_pkg.sv =====
// Shared types and constants of the indexed list buffer.
package ilb_pkg;

    // Width of list positions and counts inside the cell row (covers up to 2047 entries).
    localparam int POS_W = 11;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_FINISH
    } state_t;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic             fnd;
        logic [POS_W-1:0] at;
        logic [POS_W-1:0] cnt;
        logic [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/ilb_cell.sv =====
// One list cell: holds one entry, shifts with its neighbors and flags a match.
module ilb_cell #(
    parameter int IDX = 0
) (
    input  logic                     aclk,
    input  ilb_pkg::cell_ctl_t       ctl,
    input  logic [ilb_pkg::VAL_W-1:0] left_entry,
    input  logic [ilb_pkg::VAL_W-1:0] right_entry,
    output logic [ilb_pkg::VAL_W-1:0] entry,
    output logic                     hit
);

    localparam logic [ilb_pkg::POS_W-1:0] MY_IDX = ilb_pkg::POS_W'(IDX);

    logic [ilb_pkg::VAL_W-1:0] entry_reg;
    logic [ilb_pkg::VAL_W-1:0] entry_next;

    // Insert opens a gap at the insert position; delete pulls the upper entries down.
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (MY_IDX == ctl.at) begin
                entry_next = ctl.value;
            end else if (MY_IDX > ctl.at) begin
                entry_next = left_entry;
            end
        end else if (ctl.del) begin
            if (MY_IDX >= ctl.at) begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // A read selects this cell by position; a find by value within the valid part of the list.
    assign hit = (ctl.rd && (MY_IDX == ctl.at)) ||
                 (ctl.fnd && (entry_reg == ctl.value) && (MY_IDX < ctl.cnt));
    assign entry = entry_reg;

endmodule

// ===== rtl/ilb_tree.sv =====
// Registered priority tree that picks the lowest flagged cell and its entry.
module ilb_tree #(
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic [DEPTH-1:0]              hit_in,
    input  logic [ilb_pkg::VAL_W-1:0]     data_in [DEPTH],
    output logic                          root_hit,
    output logic [$clog2(DEPTH)-1:0]      root_pos,
    output logic [ilb_pkg::VAL_W-1:0]     root_data
);

    localparam int LVL = $clog2(DEPTH);
    localparam int LEAVES = 1 << LVL;
    localparam logic [LVL-1:0] ONE = LVL'(1);

    // Heap order: node k has children 2k and 2k+1, leaves sit at LEAVES .. 2*LEAVES-1.
    logic                      hit_reg  [1:2*LEAVES-1];
    logic [LVL-1:0]            pos_reg  [1:2*LEAVES-1];
    logic [ilb_pkg::VAL_W-1:0] data_reg [1:2*LEAVES-1];

    genvar j, k;

    // Leaf stage samples the cell row; padding leaves never win.
    generate
        for (j = 0; j < LEAVES; j++) begin : g_leaf
            if (j < DEPTH) begin : g_real
                always_ff @(posedge aclk) begin
                    hit_reg[LEAVES+j]  <= hit_in[j];
                    pos_reg[LEAVES+j]  <= '0;
                    data_reg[LEAVES+j] <= data_in[j];
                end
            end else begin : g_pad
                always_ff @(posedge aclk) begin
                    hit_reg[LEAVES+j]  <= 1'b0;
                    pos_reg[LEAVES+j]  <= '0;
                    data_reg[LEAVES+j] <= '0;
                end
            end
        end
    endgenerate

    // Each inner node prefers its lower half and adds one position bit for the upper half.
    generate
        for (k = 1; k < LEAVES; k++) begin : g_node
            localparam int HGT = LVL - ($clog2(k + 1) - 1);
            localparam logic [LVL-1:0] UPPER = ONE << (HGT - 1);
            always_ff @(posedge aclk) begin
                if (hit_reg[2*k]) begin
                    hit_reg[k]  <= 1'b1;
                    pos_reg[k]  <= pos_reg[2*k];
                    data_reg[k] <= data_reg[2*k];
                end else begin
                    hit_reg[k]  <= hit_reg[2*k+1];
                    pos_reg[k]  <= pos_reg[2*k+1] | UPPER;
                    data_reg[k] <= data_reg[2*k+1];
                end
            end
        end
    endgenerate

    assign root_hit  = hit_reg[1];
    assign root_pos  = pos_reg[1];
    assign root_data = data_reg[1];

endmodule

// ===== rtl/indexed_list_buffer.sv =====
// Top level of the indexed list buffer: sequencer, cell row, priority tree and result register.
//
// An ordered list of up to DEPTH signed 32-bit values addressed by position.
// The s_ channel takes one request (insert, delete, read or find); the m_
// channel returns exactly one result per request with a status, the read
// value, the found position and the entry count after the request.
// The list lives in a row of cells, one entry per cell. Insert and delete
// shift each cell at or above the position toward or from its neighbor; read and
// find flag matching cells, and a registered priority tree of clog2(DEPTH)
// levels picks the lowest flagged cell.
// One request is handled at a time: after acceptance it executes, then waits
// while the priority tree settles, a wait set by the depth of the tree, and its
// result is then loaded into the output register. A new request can be
// accepted from the first cycle in which the previous result sits in the
// output register. Reset empties the list and holds s_tready low; entries are
// not cleared and are never read before they are written. When the receiver
// stalls, a finished result waits in the output register, the next request is
// still accepted and runs, and its result holds in the sequencer until the
// output register is free.
module indexed_list_buffer #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command[1:0], position[9:2], item_value[41:10], zero fill [47:42]
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], read_data[33:2], found_position[39:34], entry_count[46:40], zero fill [47]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int LVL = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int WW  = $clog2(LVL + 1);
    localparam int PW  = ilb_pkg::POS_W;
    localparam int VW  = ilb_pkg::VAL_W;

    // Request register.
    ilb_pkg::cmd_t   cmd_reg;
    logic [7:0]      position_reg;
    logic [VW-1:0]   value_reg;

    ilb_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [WW-1:0]   wait_cnt_reg, wait_cnt_next;
    ilb_pkg::status_t status_reg, status_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [47:0]     m_tdata_reg, m_tdata_next;

    logic            s_accept;
    logic            exec;
    logic            load_out;

    // Position checks against the current count.
    logic            pos_neg;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic            ins_pos_ok;
    logic            idx_ok;
    logic            is_full;
    logic            do_ins;
    logic            do_del;

    ilb_pkg::cell_ctl_t ctl;

    logic [DEPTH-1:0] cell_hit;
    logic [VW-1:0]    cell_entry [DEPTH];

    logic             root_hit;
    logic [LVL-1:0]   root_pos;
    logic [VW-1:0]    root_data;

    // Result fields.
    ilb_pkg::status_t res_status;
    logic [VW-1:0]    res_data;
    logic [5:0]       res_fpos;
    logic [6:0]       res_count;

    assign s_accept = s_tvalid && s_tready;

    assign pos_neg    = position_reg[7];
    assign pos_ext    = PW'(position_reg);
    assign cnt_ext    = PW'(count_reg);
    assign ins_pos_ok = (position_reg == 8'hFF) || (!pos_neg && (pos_ext <= cnt_ext));
    assign idx_ok     = !pos_neg && (pos_ext < cnt_ext);
    assign is_full    = (count_reg == CW'(DEPTH));
    assign do_ins     = exec && (cmd_reg == ilb_pkg::CMD_INSERT) && ins_pos_ok && !is_full;
    assign do_del     = exec && (cmd_reg == ilb_pkg::CMD_DELETE) && idx_ok;

    // Broadcast to the cell row; read and find flags stay up while the tree settles.
    always_comb begin
        ctl.ins   = do_ins;
        ctl.del   = do_del;
        ctl.rd    = (cmd_reg == ilb_pkg::CMD_READ);
        ctl.fnd   = (cmd_reg == ilb_pkg::CMD_FIND);
        ctl.at    = pos_neg ? '0 : pos_ext;
        ctl.cnt   = cnt_ext;
        ctl.value = value_reg;
    end

    // Neighbor-linked cell row; value_reg is below cell 0, the top cell is its own upper.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [VW-1:0] left_entry;
            logic [VW-1:0] right_entry;
            if (i == 0) begin : g_first
                assign left_entry = value_reg;
            end else begin : g_left
                assign left_entry = cell_entry[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_entry = cell_entry[i];
            end else begin : g_right
                assign right_entry = cell_entry[i+1];
            end
            ilb_cell #(
                .IDX(i)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .left_entry (left_entry),
                .right_entry(right_entry),
                .entry      (cell_entry[i]),
                .hit        (cell_hit[i])
            );
        end
    endgenerate

    ilb_tree #(
        .DEPTH(DEPTH)
    ) u_tree (
        .aclk     (aclk),
        .hit_in   (cell_hit),
        .data_in  (cell_entry),
        .root_hit (root_hit),
        .root_pos (root_pos),
        .root_data(root_data)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ilb_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ilb_pkg::S_EXEC;
                end
            end
            ilb_pkg::S_EXEC: begin
                state_next = ilb_pkg::S_WAIT;
            end
            ilb_pkg::S_WAIT: begin
                if (wait_cnt_reg == WW'(LVL - 1)) begin
                    state_next = ilb_pkg::S_FINISH;
                end
            end
            ilb_pkg::S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ilb_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ilb_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = 1'b0;
        exec     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ilb_pkg::S_IDLE: begin
                s_tready = aresetn;
            end
            ilb_pkg::S_EXEC: begin
                exec = 1'b1;
            end
            ilb_pkg::S_WAIT: begin
                exec = 1'b0;
            end
            ilb_pkg::S_FINISH: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Count update and status of the list-changing and read requests.
    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (exec) begin
            status_next = ilb_pkg::ST_OK;
            case (cmd_reg)
                ilb_pkg::CMD_INSERT: begin
                    if (!ins_pos_ok) begin
                        status_next = ilb_pkg::ST_BADPOS;
                    end else if (is_full) begin
                        status_next = ilb_pkg::ST_FULL;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                end
                ilb_pkg::CMD_DELETE: begin
                    if (!idx_ok) begin
                        status_next = ilb_pkg::ST_BADPOS;
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                end
                ilb_pkg::CMD_READ: begin
                    if (!idx_ok) begin
                        status_next = ilb_pkg::ST_BADPOS;
                    end
                end
                default: begin
                    status_next = ilb_pkg::ST_OK;
                end
            endcase
        end
    end

    assign wait_cnt_next = exec ? '0 : wait_cnt_reg + WW'(1);

    // Assemble the result from the stored status and the tree root.
    always_comb begin
        res_status = status_reg;
        res_data   = '0;
        res_fpos   = '0;
        res_count  = 7'(PW'(count_reg));
        case (cmd_reg)
            ilb_pkg::CMD_READ: begin
                res_data = (status_reg == ilb_pkg::ST_OK) ? root_data : '1;
            end
            ilb_pkg::CMD_FIND: begin
                if (root_hit) begin
                    res_status = ilb_pkg::ST_OK;
                    res_fpos   = 6'(PW'(root_pos));
                end else begin
                    res_status = ilb_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                res_data = '0;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, res_count, res_fpos, res_data, res_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ilb_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg      <= ilb_pkg::cmd_t'(s_tdata[1:0]);
            position_reg <= s_tdata[9:2];
            value_reg    <= s_tdata[41:10];
        end
        status_reg   <= status_next;
        wait_cnt_reg <= wait_cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The list never holds more entries than the cell row.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds list depth");

    // An accepted request always starts execution in the next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ilb_pkg::S_EXEC))
        else $error("accepted request did not start execution");

    // The count moves only in the execution cycle.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ilb_pkg::S_EXEC) |=> $stable(count_reg))
        else $error("entry count changed outside execution");

    // A finished result waits while the output register is still held.
    a_finish_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ilb_pkg::S_FINISH && m_tvalid_reg && !m_tready)
        |=> (state_reg == ilb_pkg::S_FINISH))
        else $error("result overwrote a stalled output");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the indexed list buffer: request driver, result monitor and list predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 64;
    localparam int RANDOM_REQUESTS = 400;
    localparam int MAX_PRINTED = 100;

    // Expected contents of one result word.
    typedef struct packed {
        ilb_pkg::status_t status;
        logic [31:0]      read_data;
        logic [5:0]       found_pos;
        logic [6:0]       entry_count;
    } list_result_t;

    // Command mix of the random stimulus, chosen so the list fills and drains.
    typedef enum logic [1:0] {
        PH_GROW,
        PH_AT_FULL,
        PH_SHRINK,
        PH_MIXED
    } phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [47:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    // Requests waiting to be offered and results still owed by the block.
    logic [47:0]  request_queue[$];
    list_result_t expected_results[$];

    // Predicted list contents and length.
    logic [31:0] list_mem[LIST_DEPTH];
    int          list_len = 0;

    // Length the list will have once every queued request has run.
    int planned_len = 0;

    int   requests_offered = 0;
    int   requests_accepted = 0;
    int   results_seen = 0;
    int   error_count = 0;
    logic rx_hold = 1'b0;

    indexed_list_buffer #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Applies one request to the predicted list and returns the result it must produce.
    function automatic list_result_t apply_list_op(ilb_pkg::cmd_t op, logic signed [7:0] pos_raw,
                                                   logic [31:0] value);
        list_result_t res;
        int pos;
        int at;
        int i;
        logic hit;
        res.status = ilb_pkg::ST_OK;
        res.read_data = '0;
        res.found_pos = '0;
        pos = pos_raw;
        hit = 1'b0;
        case (op)
            ilb_pkg::CMD_INSERT: begin
                if (pos < -1 || pos > list_len) begin
                    res.status = ilb_pkg::ST_BADPOS;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ilb_pkg::ST_FULL;
                end else begin
                    // Both -1 and 0 put the value at the front.
                    at = (pos < 0) ? 0 : pos;
                    for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
                    list_mem[at] = value;
                    list_len++;
                end
            end
            ilb_pkg::CMD_DELETE: begin
                if (pos < 0 || pos >= list_len) begin
                    res.status = ilb_pkg::ST_BADPOS;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ilb_pkg::CMD_READ: begin
                if (pos < 0 || pos >= list_len) begin
                    res.status = ilb_pkg::ST_BADPOS;
                    res.read_data = '1;
                end else begin
                    res.read_data = list_mem[pos];
                end
            end
            default: begin
                // The lowest matching position wins.
                for (i = 0; i < list_len && !hit; i++) begin
                    if (list_mem[i] == value) begin
                        hit = 1'b1;
                        res.found_pos = i[5:0];
                    end
                end
                if (!hit) res.status = ilb_pkg::ST_NOTFOUND;
            end
        endcase
        res.entry_count = list_len[6:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
        end
    endtask

    // Compares one result word with the oldest expectation.
    task automatic check_result(logic [47:0] word);
        list_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding", word[33:2], '0);
        end else begin
            want = expected_results.pop_front();
            if (word[1:0] != want.status)
                report_mismatch("status", 32'(word[1:0]), 32'(want.status));
            if (word[33:2] != want.read_data)
                report_mismatch("read_data", word[33:2], want.read_data);
            if (word[39:34] != want.found_pos)
                report_mismatch("found_position", 32'(word[39:34]), 32'(want.found_pos));
            if (word[46:40] != want.entry_count)
                report_mismatch("entry_count", 32'(word[46:40]), 32'(want.entry_count));
        end
        results_seen++;
    endtask

    // Packs a request and tracks how it will change the list length.
    task automatic queue_request(ilb_pkg::cmd_t op, int pos, logic [31:0] value);
        logic signed [7:0] p8;
        int at;
        p8 = pos[7:0];
        at = p8;
        request_queue.push_back({6'd0, value, p8, op});
        if (op == ilb_pkg::CMD_INSERT && at >= -1 && at <= planned_len &&
            planned_len < LIST_DEPTH)
            planned_len++;
        else if (op == ilb_pkg::CMD_DELETE && at >= 0 && at < planned_len)
            planned_len--;
    endtask

    function automatic ilb_pkg::cmd_t pick_command(int insert_pct, int delete_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct) return ilb_pkg::CMD_INSERT;
        if (r < insert_pct + delete_pct) return ilb_pkg::CMD_DELETE;
        return ($urandom_range(0, 1) != 0) ? ilb_pkg::CMD_READ : ilb_pkg::CMD_FIND;
    endfunction

    // Mostly valid positions, some just outside the valid range, some any 8-bit pattern.
    function automatic int pick_position(ilb_pkg::cmd_t op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(0, 255);
        if (r < 14) begin
            if (op == ilb_pkg::CMD_INSERT)
                return ($urandom_range(0, 1) != 0) ? planned_len + 1 : -2;
            return ($urandom_range(0, 1) != 0) ? planned_len : -1;
        end
        if (op == ilb_pkg::CMD_INSERT) return int'($urandom_range(0, planned_len + 1)) - 1;
        if (planned_len == 0) return 0;
        return $urandom_range(0, planned_len - 1);
    endfunction

    // Small values make finds hit and create duplicates; the rest cover all bits.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) != 0) return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // Idling is switched off for a stretch in the middle of the run.
    function automatic int idle_pct();
        return (requests_accepted >= 150 && requests_accepted < 260) ? 0 : 25;
    endfunction

    // Request driver: holds an offered request until the monitor has seen it taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || requests_accepted == requests_offered) begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= request_queue.pop_front();
                    requests_offered++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver readiness.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= idle_pct());
        end
    end

    // Monitor: checks results, then predicts accepted requests.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_op(ilb_pkg::cmd_t'(s_tdata[1:0]),
                                                         s_tdata[9:2], s_tdata[41:10]));
                requests_accepted++;
            end
        end
    end

    // Long receiver stall while requests keep coming, so the block backs up.
    initial begin
        while (requests_accepted < 60) @(negedge aclk);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (200) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        phase_t phase;
        int phase_items;
        int n;
        ilb_pkg::cmd_t op;

        // Empty list: find misses, read and delete have no valid position.
        queue_request(ilb_pkg::CMD_FIND, 0, 32'h0);
        queue_request(ilb_pkg::CMD_READ, 0, 32'h0);
        queue_request(ilb_pkg::CMD_DELETE, 0, 32'h0);
        // Front by -1 and by 0, append at the end, then insert in the middle.
        queue_request(ilb_pkg::CMD_INSERT, -1, 32'h8000_0000);
        queue_request(ilb_pkg::CMD_INSERT, 0, 32'h7FFF_FFFF);
        queue_request(ilb_pkg::CMD_INSERT, 2, 32'hFFFF_FFFF);
        queue_request(ilb_pkg::CMD_INSERT, 1, 32'h0000_0000);
        // Insert positions past the end and below -1, including the 8-bit extremes.
        queue_request(ilb_pkg::CMD_INSERT, 5, 32'h1111_1111);
        queue_request(ilb_pkg::CMD_INSERT, -2, 32'h2222_2222);
        queue_request(ilb_pkg::CMD_INSERT, -128, 32'hA5A5_A5A5);
        queue_request(ilb_pkg::CMD_INSERT, 127, 32'h5A5A_5A5A);
        // Read every entry, then one past the end and one below zero.
        for (n = 0; n < 4; n++) queue_request(ilb_pkg::CMD_READ, n, 32'h0);
        queue_request(ilb_pkg::CMD_READ, 4, 32'h0);
        queue_request(ilb_pkg::CMD_READ, -1, 32'h0);
        // Find a present and an absent value, then a duplicate that must report the first.
        queue_request(ilb_pkg::CMD_FIND, 0, 32'hFFFF_FFFF);
        queue_request(ilb_pkg::CMD_FIND, 0, 32'h1234_5678);
        queue_request(ilb_pkg::CMD_INSERT, 3, 32'h7FFF_FFFF);
        queue_request(ilb_pkg::CMD_FIND, 0, 32'h7FFF_FFFF);
        // Delete in the middle and at the tail, then at bad positions.
        queue_request(ilb_pkg::CMD_DELETE, 1, 32'h0);
        queue_request(ilb_pkg::CMD_DELETE, 3, 32'h0);
        queue_request(ilb_pkg::CMD_DELETE, 3, 32'h0);
        queue_request(ilb_pkg::CMD_DELETE, -1, 32'h0);

        // Random part: fill the list, work it while full, drain it, then mix.
        phase = PH_GROW;
        phase_items = 0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            case (phase)
                PH_GROW:    op = pick_command(70, 10);
                PH_AT_FULL: op = pick_command(50, 20);
                PH_SHRINK:  op = pick_command(10, 70);
                default:    op = pick_command(25, 25);
            endcase
            queue_request(op, pick_position(op), pick_value());
            phase_items++;
            case (phase)
                PH_GROW: begin
                    if (planned_len == LIST_DEPTH) begin
                        phase = PH_AT_FULL;
                        phase_items = 0;
                    end
                end
                PH_AT_FULL: begin
                    if (phase_items == 16) begin
                        phase = PH_SHRINK;
                        phase_items = 0;
                    end
                end
                PH_SHRINK: begin
                    if (planned_len == 0) begin
                        phase = PH_MIXED;
                        phase_items = 0;
                    end
                end
                default: begin
                    if (phase_items == 40) begin
                        phase = PH_GROW;
                        phase_items = 0;
                    end
                end
            endcase
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken and every result to come back.
        while (request_queue.size() != 0 || s_tvalid) @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
